### hdl/pfhl_pkg.sv
`timescale 1ns / 1ps

package pfhl_pkg;

  localparam int TABLE_BITS   = 10;
  localparam int SLOT_COUNT   = 1 << TABLE_BITS;
  localparam int MAX_DISTINCT = 1024;
  localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);

  localparam logic [15:0] TOL_RESET = 16'd168;

  localparam logic [7:0] CLASS_FIRST  = 8'h01;
  localparam logic [7:0] CLASS_SECOND = 8'h02;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic    clr;
    logic    load;
    logic    rd;
    logic    step;
    logic    calc_diff;
    logic    insert;
    logic    merge;
    logic    emit;
    logic    slot_zero;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic id_zero;
    logic cat;
    logic key_empty;
    logic key_match;
    logic probe_last;
    logic in_tol;
  } sts_t;

endpackage

### hdl/pfhl_ctrl.sv
`timescale 1ns / 1ps

module pfhl_ctrl import pfhl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_CHECK  = 5'b01000,
    S_TOLCHK = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.code = ST_INSERTED;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (sts_i.id_zero) begin
            cmd_o.emit      = 1'b1;
            cmd_o.slot_zero = 1'b1;
            cmd_o.code      = ST_DUPLICATE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.key_empty) begin
          cmd_o.insert = 1'b1;
          cmd_o.emit   = 1'b1;
          cmd_o.code   = ST_INSERTED;
          state_d      = S_IDLE;
        end else if (sts_i.key_match) begin
          if (!sts_i.cat) begin
            cmd_o.emit = 1'b1;
            cmd_o.code = ST_DUPLICATE;
            state_d    = S_IDLE;
          end else begin
            cmd_o.calc_diff = 1'b1;
            state_d         = S_TOLCHK;
          end
        end else if (sts_i.probe_last) begin
          cmd_o.emit      = 1'b1;
          cmd_o.slot_zero = 1'b1;
          cmd_o.code      = ST_FULL;
          state_d         = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = S_READ;
        end
      end
      S_TOLCHK: begin
        cmd_o.emit = 1'b1;
        if (sts_i.in_tol) begin
          cmd_o.merge = 1'b1;
          cmd_o.code  = ST_MERGED;
        end else begin
          cmd_o.code = ST_MISMATCH;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

### hdl/pfhl_datapath.sv
`timescale 1ns / 1ps

module pfhl_datapath import pfhl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ref_tolerance_we_i,
  input  logic [15:0]       ref_tolerance_i,
  input  logic              category_i,
  input  logic [31:0]       token_id_i,
  input  logic signed [31:0] weight_i,
  input  logic signed [31:0] reference_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic              result_valid_o,
  output logic [2:0]        status_o,
  output logic [9:0]        slot_index_o,
  output logic [CNT_W-1:0]  unique_count_o,
  output logic              count_overflow_o
);

  logic [31:0] key_mem   [SLOT_COUNT];
  logic [31:0] ref_mem   [SLOT_COUNT];
  logic [31:0] wf_mem    [SLOT_COUNT];
  logic [31:0] ws_mem    [SLOT_COUNT];
  logic [7:0]  class_mem [SLOT_COUNT];

  logic [15:0]           tol_q;
  logic [TABLE_BITS-1:0] clr_cnt_q;
  logic                  cat_q;
  logic [31:0]           id_q, w_q, ref_q;
  logic [TABLE_BITS-1:0] pos_q, pcnt_q;
  logic [31:0]           key_rd_q, ref_rd_q;
  logic [7:0]            class_rd_q;
  logic signed [32:0]    diff_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  ovf_q, ovf_d;
  logic                  valid_q;
  logic [2:0]            status_q;
  logic [9:0]            slot_q;
  logic [CNT_W-1:0]      ucnt_q;
  logic                  uovf_q;

  logic [TABLE_BITS-1:0] wa;
  logic [7:0]            class_wd;
  logic signed [33:0]    diff_x, tol_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (ref_tolerance_we_i) begin
      tol_q <= ref_tolerance_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cat_q  <= category_i;
      id_q   <= token_id_i;
      w_q    <= weight_i;
      ref_q  <= reference_i;
      pos_q  <= token_id_i[TABLE_BITS-1:0];
      pcnt_q <= '0;
    end else if (cmd_i.step) begin
      pos_q  <= pos_q + 1'b1;
      pcnt_q <= pcnt_q + 1'b1;
    end
    if (cmd_i.calc_diff) begin
      diff_q <= $signed({ref_q[31], ref_q}) - $signed({ref_rd_q[31], ref_rd_q});
    end
  end

  // table storage: one write port, one registered read port
  assign wa = cmd_i.clr ? clr_cnt_q : pos_q;

  always_comb begin
    if (cmd_i.clr) begin
      class_wd = '0;
    end else if (cmd_i.insert) begin
      class_wd = class_rd_q | (cat_q ? CLASS_SECOND : CLASS_FIRST);
    end else begin
      class_wd = class_rd_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr || cmd_i.insert) begin
      key_mem[wa] <= cmd_i.clr ? 32'd0 : id_q;
      ref_mem[wa] <= cmd_i.clr ? 32'd0 : ref_q;
    end
    if (cmd_i.clr || (cmd_i.insert && !cat_q)) begin
      wf_mem[wa] <= cmd_i.clr ? 32'd0 : w_q;
    end
    if (cmd_i.clr || (cmd_i.insert && cat_q) || cmd_i.merge) begin
      ws_mem[wa] <= cmd_i.clr ? 32'd0 : w_q;
    end
    if (cmd_i.clr || cmd_i.insert || cmd_i.merge) begin
      class_mem[wa] <= class_wd;
    end
    if (cmd_i.rd) begin
      key_rd_q   <= key_mem[pos_q];
      ref_rd_q   <= ref_mem[pos_q];
      class_rd_q <= class_mem[pos_q];
    end
  end

  assign diff_x = {diff_q[32], diff_q};
  assign tol_x  = $signed({18'd0, tol_q});

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.insert) begin
      if (cnt_q < CNT_W'(MAX_DISTINCT)) cnt_d = cnt_q + 1'b1;
      else ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.code;
      slot_q   <= cmd_i.slot_zero ? 10'd0 : 10'(pos_q);
      ucnt_q   <= cnt_d;
      uovf_q   <= ovf_d;
    end
  end

  assign sts_o.clr_last   = &clr_cnt_q;
  assign sts_o.id_zero    = (token_id_i == 32'd0);
  assign sts_o.cat        = cat_q;
  assign sts_o.key_empty  = (key_rd_q == 32'd0);
  assign sts_o.key_match  = (key_rd_q == id_q);
  assign sts_o.probe_last = &pcnt_q;
  assign sts_o.in_tol     = (diff_x <= tol_x) && (diff_x >= -tol_x);

  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign slot_index_o     = slot_q;
  assign unique_count_o   = ucnt_q;
  assign count_overflow_o = uovf_q;

endmodule

### hdl/paired_feature_hash_loader.sv
`timescale 1ns / 1ps
// A zero id is answered without a table probe; other items probe slot by slot, and a key
// match for the second category adds a tolerance check. Items are taken one at a time; busy
// is high while one is probed. Each probe uses the single table read port, in a read and a check state.
// A full table is reported only after all 1024 slots have been probed.
// Reset: asynchronous, active low; a clearing pass over all 1024 slots follows, busy stays high.
// The result strobe lasts one cycle; the receiver cannot stall.
module paired_feature_hash_loader import pfhl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ref_tolerance_we_i,
  input  logic [15:0]        ref_tolerance_i,
  input  logic               start,
  output logic               busy,
  input  logic               category_i,
  input  logic [31:0]        token_id_i,
  input  logic signed [31:0] weight_i,
  input  logic signed [31:0] reference_i,
  output logic               result_valid_o,
  output logic [2:0]         status_o,
  output logic [9:0]         slot_index_o,
  output logic [10:0]        unique_count_o,
  output logic               count_overflow_o
);

  cmd_t cmd;
  sts_t sts;

  pfhl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  pfhl_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ref_tolerance_we_i (ref_tolerance_we_i),
    .ref_tolerance_i    (ref_tolerance_i),
    .category_i         (category_i),
    .token_id_i         (token_id_i),
    .weight_i           (weight_i),
    .reference_i        (reference_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .result_valid_o     (result_valid_o),
    .status_o           (status_o),
    .slot_index_o       (slot_index_o),
    .unique_count_o     (unique_count_o),
    .count_overflow_o   (count_overflow_o)
  );

  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && token_id_i == 32'd0) |=>
      (result_valid_o && status_o == ST_DUPLICATE && slot_index_o == 10'd0))
    else $error("zero id item not reported as ignored");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == ST_FULL) |-> (slot_index_o == 10'd0))
    else $error("table full result with nonzero slot");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && count_overflow_o) |-> (unique_count_o == 11'(MAX_DISTINCT)))
    else $error("overflow flagged below saturation");

  a_busy_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != ST_DUPLICATE) |-> $past(busy))
    else $error("probed result without a busy cycle");

endmodule

### dv/tb_paired_feature_hash_loader.sv
`timescale 1ns / 1ps

module tb_paired_feature_hash_loader;
  import pfhl_pkg::*;

  localparam int STALL_LIMIT = 8 * (2 * SLOT_COUNT + 40);
  localparam int POOL_CAP    = 350;

  typedef struct packed {
    logic        cat;
    logic [31:0] id;
    logic [31:0] wt;
    logic [31:0] refv;
  } feature_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  slot;
    logic [10:0] count;
    logic        ovf;
  } load_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        ref_tolerance_we_i = 1'b0;
  logic [15:0] ref_tolerance_i = 16'd0;
  logic        start = 1'b0;
  logic        busy;
  logic        category_i = 1'b0;
  logic [31:0] token_id_i = 32'd0;
  logic [31:0] weight_i = 32'd0;
  logic [31:0] reference_i = 32'd0;
  logic        result_valid_o;
  logic [2:0]  status_o;
  logic [9:0]  slot_index_o;
  logic [10:0] unique_count_o;
  logic        count_overflow_o;

  // shadow of the slot table
  logic [31:0] tbl_key     [SLOT_COUNT];
  logic [31:0] tbl_wfirst  [SLOT_COUNT];
  logic [31:0] tbl_wsecond [SLOT_COUNT];
  logic [31:0] tbl_ref     [SLOT_COUNT];
  logic [7:0]  tbl_class   [SLOT_COUNT];
  int          tbl_distinct = 0;
  logic        tbl_ovf = 1'b0;
  logic [15:0] tbl_tol = TOL_RESET;

  feature_t      pending_items[$];
  load_outcome_t load_outcomes[$];
  logic [31:0]   pool_id[$];
  logic [31:0]   pool_ref[$];

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  int gap_left = 0;
  bit idle_on = 1'b0;
  int status_seen[5] = '{default: 0};

  paired_feature_hash_loader dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ref_tolerance_we_i(ref_tolerance_we_i),
    .ref_tolerance_i   (ref_tolerance_i),
    .start             (start),
    .busy              (busy),
    .category_i        (category_i),
    .token_id_i        (token_id_i),
    .weight_i          (weight_i),
    .reference_i       (reference_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .unique_count_o    (unique_count_o),
    .count_overflow_o  (count_overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int s = 0; s < SLOT_COUNT; s++) begin
      tbl_key[s] = '0;
      tbl_wfirst[s] = '0;
      tbl_wsecond[s] = '0;
      tbl_ref[s] = '0;
      tbl_class[s] = '0;
    end
  end

  function automatic load_outcome_t probe_and_load(input feature_t f);
    load_outcome_t o;
    int unsigned   pos;
    int unsigned   n;
    bit            hit;
    longint        diff;
    o.status = ST_DUPLICATE;
    o.slot = '0;
    hit = 1'b0;
    n = 0;
    pos = f.id[TABLE_BITS-1:0];
    if (f.id != 32'd0) begin
      while (!hit && n < SLOT_COUNT) begin
        if (tbl_key[pos] == 32'd0 || tbl_key[pos] == f.id) begin
          hit = 1'b1;
        end else begin
          pos = (pos + 1) % SLOT_COUNT;
          n++;
        end
      end
      if (!hit) begin
        o.status = ST_FULL;
      end else begin
        o.slot = pos[9:0];
        if (tbl_key[pos] == 32'd0) begin
          tbl_key[pos] = f.id;
          if (!f.cat) begin
            tbl_wfirst[pos] = f.wt;
            tbl_class[pos] = tbl_class[pos] | CLASS_FIRST;
          end else begin
            tbl_wsecond[pos] = f.wt;
            tbl_class[pos] = tbl_class[pos] | CLASS_SECOND;
          end
          tbl_ref[pos] = f.refv;
          if (tbl_distinct < MAX_DISTINCT) tbl_distinct++;
          else tbl_ovf = 1'b1;
          o.status = ST_INSERTED;
        end else if (f.cat) begin
          diff = longint'($signed(f.refv)) - longint'($signed(tbl_ref[pos]));
          if (diff < 0) diff = -diff;
          if (diff > longint'(tbl_tol)) begin
            o.status = ST_MISMATCH;
          end else begin
            tbl_wsecond[pos] = f.wt;
            tbl_class[pos] = tbl_class[pos] + 8'd1;
            o.status = ST_MERGED;
          end
        end
      end
    end
    o.count = 11'(tbl_distinct);
    o.ovf = tbl_ovf;
    status_seen[int'(o.status)]++;
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic     took;
    feature_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      category_i <= 1'b0;
      token_id_i <= '0;
      weight_i <= '0;
      reference_i <= '0;
    end else begin
      took = start && !busy;
      if (took) begin
        load_outcomes.push_back(probe_and_load({category_i, token_id_i, weight_i,
                                                reference_i}));
        n_accepted++;
        if (idle_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
      end
      if (took || !start) begin
        if (gap_left > 0 || pending_items.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          start <= 1'b1;
          category_i <= nxt.cat;
          token_id_i <= nxt.id;
          weight_i <= nxt.wt;
          reference_i <= nxt.refv;
        end
      end
    end
  end

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // monitor
  always @(posedge clk_i) begin : watch
    load_outcome_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      n_results++;
      if (load_outcomes.size() == 0) begin
        report($sformatf("result %0d arrived with no item outstanding", n_results));
      end else begin
        want = load_outcomes.pop_front();
        if (status_o !== want.status || slot_index_o !== want.slot ||
            unique_count_o !== want.count || count_overflow_o !== want.ovf)
          report($sformatf({"result %0d: status %0d/%0d slot %0d/%0d count %0d/%0d",
                            " overflow %0d/%0d (expected/actual)"},
                           n_results, want.status, status_o, want.slot, slot_index_o,
                           want.count, unique_count_o, want.ovf, count_overflow_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || result_valid_o === 1'b1)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic add_feature(input logic cat, input logic [31:0] id,
                             input logic [31:0] wt, input logic [31:0] refv);
    pending_items.push_back({cat, id, wt, refv});
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_results < n_queued || busy !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic retune(input logic [15:0] tol);
    wait_drained();
    @(posedge clk_i);
    ref_tolerance_we_i <= 1'b1;
    ref_tolerance_i <= tol;
    @(posedge clk_i);
    ref_tolerance_we_i <= 1'b0;
    tbl_tol = tol;
  endtask

  task automatic random_features(input int n);
    int          i;
    int          k;
    int          pick;
    int          span;
    int          d;
    logic [31:0] id;
    logic [31:0] r;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      k = (pool_id.size() > 0) ? $urandom_range(0, pool_id.size() - 1) : 0;
      if ((pick < 35 && pool_id.size() < POOL_CAP) || pool_id.size() == 0) begin
        id = $urandom;
        if (pool_id.size() > 0 && $urandom_range(0, 3) == 0) id[9:0] = pool_id[k][9:0];
        if (id == 32'd0) id = 32'h400;
        r = $urandom;
        pool_id.push_back(id);
        pool_ref.push_back(r);
        add_feature(1'($urandom_range(0, 1)), id, $urandom, r);
      end else if (pick < 75) begin
        span = int'(tbl_tol) + 3;
        case ($urandom_range(0, 4))
          0: d = int'(tbl_tol);
          1: d = -int'(tbl_tol);
          2: d = int'(tbl_tol) + 1;
          3: d = -int'(tbl_tol) - 1;
          default: d = int'($urandom_range(0, 2 * span)) - span;
        endcase
        r = pool_ref[k] + d;
        add_feature(1'b1, pool_id[k], $urandom, r);
      end else if (pick < 88) begin
        add_feature(1'b0, pool_id[k], $urandom, $urandom);
      end else if (pick < 93) begin
        add_feature(1'($urandom_range(0, 1)), 32'd0, $urandom, $urandom);
      end else begin
        add_feature(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin : stimulus
    int          s;
    int          i;
    logic [31:0] id;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset tolerance
    idle_on = 1'b1;
    add_feature(1'b0, 32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_feature(1'b1, 32'd0, 32'h80000000, 32'h80000000);
    add_feature(1'b0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_feature(1'b0, 32'h000003FF, 32'h80000000, 32'h80000000);  // wraps to slot 0
    add_feature(1'b1, 32'h000007FF, 32'hFFFFFFFF, 32'h00000000);
    add_feature(1'b0, 32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF);
    add_feature(1'b1, 32'hFFFFFFFF, 32'h00000001, 32'h80000000);  // 33-bit difference
    add_feature(1'b1, 32'h000003FF, 32'h12345678, 32'h80000000 + 32'd168);
    add_feature(1'b1, 32'h000003FF, 32'h12345678, 32'h80000000 + 32'd169);
    add_feature(1'b1, 32'h000003FF, 32'h0000FFFF, 32'h80000000);
    add_feature(1'b1, 32'h00000001, 32'hA5A5A5A5, 32'h00001000);
    add_feature(1'b1, 32'h00000001, 32'h5A5A5A5A, 32'h00001000 - 32'd168);
    add_feature(1'b0, 32'h00000001, 32'h5A5A5A5A, 32'h00001000);
    retune(16'd0);
    add_feature(1'b1, 32'h00000001, 32'h00000000, 32'h00001000);
    add_feature(1'b1, 32'h00000001, 32'h00000000, 32'h00001001);
    retune(16'hFFFF);
    add_feature(1'b1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFF0000);
    add_feature(1'b1, 32'hFFFFFFFF, 32'h80000000, 32'h7FFEFFFF);

    retune(16'($urandom_range(1, 65534)));
    random_features(250);
    retune(16'd0);
    idle_on = 1'b0;
    random_features(200);
    retune(16'hFFFF);
    idle_on = 1'b1;
    random_features(250);
    retune(TOL_RESET);
    random_features(200);

    // no idling from here: fill every free slot at its home position
    wait_drained();
    idle_on = 1'b0;
    gap_left = 0;
    for (s = 0; s < SLOT_COUNT; s++) begin
      if (tbl_key[s] == 32'd0) begin
        id = $urandom;
        id[TABLE_BITS-1:0] = s[TABLE_BITS-1:0];
        if (id == 32'd0) id[31] = 1'b1;
        add_feature(1'($urandom_range(0, 1)), id, $urandom, $urandom);
      end
    end

    // table full
    wait_drained();
    for (i = 0; i < 24; i++) begin
      s = $urandom_range(0, SLOT_COUNT - 1);
      case (i % 4)
        0: add_feature(1'($urandom_range(0, 1)), $urandom | 32'd1, $urandom, $urandom);
        1: add_feature(1'b1, tbl_key[s], $urandom, tbl_ref[s]);
        2: add_feature(1'b0, tbl_key[s], $urandom, $urandom);
        default: add_feature(1'b1, tbl_key[s], $urandom, tbl_ref[s] + tbl_tol + 32'd1);
      endcase
    end
    add_feature(1'b1, 32'd0, $urandom, $urandom);

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (load_outcomes.size() != 0)
      report($sformatf("%0d results never arrived", load_outcomes.size()));
    $display("%0d items: %0d inserted, %0d merged, %0d duplicate or zero id, %0d mismatch, %0d full",
             n_accepted, status_seen[ST_INSERTED], status_seen[ST_MERGED],
             status_seen[ST_DUPLICATE], status_seen[ST_MISMATCH], status_seen[ST_FULL]);
    $display("tolerances 168, 0, 65535 and random; %0d distinct ids held, %0d mismatches",
             tbl_distinct, fail_count);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hdl/pfhl_pkg.sv
hdl/pfhl_ctrl.sv
hdl/pfhl_datapath.sv
hdl/paired_feature_hash_loader.sv
dv/tb_paired_feature_hash_loader.sv
